// ===== hdl/dq_pkg.sv =====
// Shared definitions for the double-ended queue core.
// Holds command and status codes, field widths and the default depth.
// No dependencies.
package dq_pkg;

    localparam int DQ_DEPTH   = 16;
    localparam int CMD_W      = 2;
    localparam int DATA_W     = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

endpackage

// ===== hdl/dq_ram.sv =====
// Ring store of the queue: one write port, two registered read ports.
// Uses dq_pkg for the word width.
module dq_ram #(
    parameter int  DEPTH = dq_pkg::DQ_DEPTH,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [dq_pkg::DATA_W-1:0]  i_wdata,
    input  logic [AW-1:0]              i_raddr_a,
    input  logic [AW-1:0]              i_raddr_b,
    output logic [dq_pkg::DATA_W-1:0]  o_rdata_a,
    output logic [dq_pkg::DATA_W-1:0]  o_rdata_b
);
    import dq_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata_a;
    logic [DATA_W-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== hdl/dq_ctrl.sv =====
// Command sequencer of the queue: head index, fill count and result registers.
// Uses dq_pkg codes; drives the ring store in dq_ram.
module dq_ctrl #(
    parameter int  DEPTH = dq_pkg::DQ_DEPTH,
    localparam int AW    = $clog2(DEPTH),
    localparam int CW    = $clog2(DEPTH + 1)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [dq_pkg::CMD_W-1:0]     i_cmd,
    input  logic [dq_pkg::DATA_W-1:0]    i_value,
    output logic                         o_we,
    output logic [AW-1:0]                o_waddr,
    output logic [dq_pkg::DATA_W-1:0]    o_wdata,
    output logic [AW-1:0]                o_raddr_front,
    output logic [AW-1:0]                o_raddr_back,
    input  logic [dq_pkg::DATA_W-1:0]    i_rdata_front,
    input  logic [dq_pkg::DATA_W-1:0]    i_rdata_back,
    output logic                         o_valid,
    output logic [dq_pkg::STATUS_W-1:0]  o_status,
    output logic [dq_pkg::DATA_W-1:0]    o_front_value,
    output logic [dq_pkg::DATA_W-1:0]    o_back_value,
    output logic [dq_pkg::COUNT_W-1:0]   o_count,
    output logic                         o_is_empty
);
    import dq_pkg::*;

    localparam int SW = AW + 1;
    localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_OUT
    } t_state;

    t_state              r_state;
    logic [AW-1:0]       r_head;
    logic [CW-1:0]       r_count;
    logic [STATUS_W-1:0] r_status;
    logic                r_valid;

    logic                accept;
    logic [AW-1:0]       n_head;
    logic [CW-1:0]       n_count;
    logic [STATUS_W-1:0] n_status;
    logic [SW-1:0]       tail_sum;
    logic [SW-1:0]       back_sum;
    logic [AW-1:0]       tail_pos;
    logic [AW-1:0]       head_dec;
    logic [AW-1:0]       head_inc;
    logic                full;
    logic                empty;

    // Hold busy high during reset so no request is taken then.
    assign busy   = (r_state != S_IDLE) || !i_rst_n;
    assign accept = start && !busy;
    assign full   = (r_count == DEPTH_C);
    assign empty  = (r_count == '0);

    // Ring positions: operands stay below twice the depth, so one wrap suffices.
    always_comb begin
        tail_sum = SW'(r_head) + SW'(r_count);
        tail_pos = (tail_sum >= DEPTH_S) ? AW'(tail_sum - DEPTH_S) : AW'(tail_sum);
        head_dec = (r_head == '0) ? AW'(DEPTH - 1) : AW'(r_head - 1'b1);
        head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : AW'(r_head + 1'b1);
        back_sum = tail_sum - SW'(1);
        if (empty) begin
            o_raddr_back = r_head;
        end else if (back_sum >= DEPTH_S) begin
            o_raddr_back = AW'(back_sum - DEPTH_S);
        end else begin
            o_raddr_back = AW'(back_sum);
        end
    end

    assign o_raddr_front = r_head;
    assign o_wdata       = i_value;

    always_comb begin
        n_head   = r_head;
        n_count  = r_count;
        n_status = ST_DONE;
        o_we     = 1'b0;
        o_waddr  = tail_pos;
        unique case (i_cmd)
            CMD_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_head  = head_dec;
                    n_count = r_count + 1'b1;
                    o_we    = accept;
                    o_waddr = head_dec;
                end
            end
            CMD_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    n_count = r_count + 1'b1;
                    o_we    = accept;
                end
            end
            CMD_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_head  = head_inc;
                    n_count = r_count - 1'b1;
                end
            end
            CMD_POP_BACK: begin
                if (empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            default: begin
                n_status = ST_DONE;
            end
        endcase
    end

    // Update pointers at the request, read both ends next, then show the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_status <= ST_DONE;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_head   <= n_head;
                        r_count  <= n_count;
                        r_status <= n_status;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_valid <= 1'b1;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_is_empty    = empty;
    assign o_count       = COUNT_W'(r_count);
    assign o_front_value = empty ? '0 : i_rdata_front;
    assign o_back_value  = empty ? '0 : i_rdata_back;

endmodule

// ===== hdl/double_ended_queue_core.sv =====
// Double-ended queue core: bounded deque of 32-bit words in a ring store.
// Request flow: pointer update and write when the request is taken, registered read of
// both ends, then the result strobe o_valid with busy still high, so no new request is taken
// until the result has been shown. The receiver cannot stall.
// Reset (synchronous, active low) empties the queue and holds busy; store not cleared.
// Depends on dq_pkg, dq_ctrl and dq_ram.
module double_ended_queue_core #(
    parameter int DEPTH = dq_pkg::DQ_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [dq_pkg::CMD_W-1:0]     i_cmd,
    input  logic [dq_pkg::DATA_W-1:0]    i_value,
    output logic                         o_valid,
    output logic [dq_pkg::STATUS_W-1:0]  o_status,
    output logic [dq_pkg::DATA_W-1:0]    o_front_value,
    output logic [dq_pkg::DATA_W-1:0]    o_back_value,
    output logic [dq_pkg::COUNT_W-1:0]   o_count,
    output logic                         o_is_empty
);
    import dq_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr_front;
    logic [AW-1:0]     mem_raddr_back;
    logic [DATA_W-1:0] mem_rdata_front;
    logic [DATA_W-1:0] mem_rdata_back;

    dq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .o_we           (mem_we),
        .o_waddr        (mem_waddr),
        .o_wdata        (mem_wdata),
        .o_raddr_front  (mem_raddr_front),
        .o_raddr_back   (mem_raddr_back),
        .i_rdata_front  (mem_rdata_front),
        .i_rdata_back   (mem_rdata_back),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value),
        .o_count        (o_count),
        .o_is_empty     (o_is_empty)
    );

    dq_ram #(
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_raddr_a (mem_raddr_front),
        .i_raddr_b (mem_raddr_back),
        .o_rdata_a (mem_rdata_front),
        .o_rdata_b (mem_rdata_back)
    );

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for double_ended_queue_core: directed corner cases, then biased random
// push/pop traffic, checked against a ring-store prediction of the deque. Depends on dq_pkg and the core.
module tb_top;
    import dq_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [DATA_W-1:0]   front_value;
        logic [DATA_W-1:0]   back_value;
        logic [COUNT_W-1:0]  count;
        logic                is_empty;
    } t_dq_result;

    class dq_scoreboard;
        logic [DATA_W-1:0] ring [DQ_DEPTH];
        int head;
        int fill;
        int errors;
        t_dq_result deque_results_q[$];

        function new();
            head   = 0;
            fill   = 0;
            errors = 0;
        endfunction

        function int pending();
            return deque_results_q.size();
        endfunction

        // Apply one accepted request to the ring image and queue the result it produces.
        function void note_request(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val);
            t_dq_result r;
            r.status = ST_DONE;
            if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK) begin
                if (fill >= DQ_DEPTH) begin
                    r.status = ST_OVERFLOW;
                end else if (cmd == CMD_PUSH_FRONT) begin
                    head = (head + DQ_DEPTH - 1) % DQ_DEPTH;
                    ring[head] = val;
                    fill++;
                end else begin
                    ring[(head + fill) % DQ_DEPTH] = val;
                    fill++;
                end
            end else begin
                if (fill == 0) begin
                    r.status = ST_UNDERFLOW;
                end else if (cmd == CMD_POP_FRONT) begin
                    head = (head + 1) % DQ_DEPTH;
                    fill--;
                end else begin
                    fill--;
                end
            end
            r.front_value = '0;
            r.back_value  = '0;
            if (fill != 0) begin
                r.front_value = ring[head];
                r.back_value  = ring[(head + fill - 1) % DQ_DEPTH];
            end
            r.count    = COUNT_W'(fill);
            r.is_empty = (fill == 0);
            deque_results_q.push_back(r);
        endfunction

        function void compare_field(string name, logic [DATA_W-1:0] exp_v,
                                    logic [DATA_W-1:0] act_v);
            if (exp_v !== act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_dq_result got);
            t_dq_result want;
            if (deque_results_q.size() == 0) begin
                errors++;
                $display("%0t: result with nothing outstanding, actual %h", $time, got);
                return;
            end
            want = deque_results_q.pop_front();
            compare_field("status", DATA_W'(want.status), DATA_W'(got.status));
            compare_field("front_value", want.front_value, got.front_value);
            compare_field("back_value", want.back_value, got.back_value);
            compare_field("count", DATA_W'(want.count), DATA_W'(got.count));
            compare_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [CMD_W-1:0]    i_cmd;
    logic [DATA_W-1:0]   i_value;
    logic                o_valid;
    logic [STATUS_W-1:0] o_status;
    logic [DATA_W-1:0]   o_front_value;
    logic [DATA_W-1:0]   o_back_value;
    logic [COUNT_W-1:0]  o_count;
    logic                o_is_empty;

    dq_scoreboard sb;
    int           cycle_count;

    double_ended_queue_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_front_value (o_front_value),
        .o_back_value  (o_back_value),
        .o_count       (o_count),
        .o_is_empty    (o_is_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sample the handshake and the result strobe with pre-edge values.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (start === 1'b1 && busy === 1'b0)
                sb.note_request(i_cmd, i_value);
            if (o_valid === 1'b1)
                sb.check_result({o_status, o_front_value, o_back_value, o_count, o_is_empty});
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Present one request and hold it until the core takes it.
    task automatic send_req(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] val);
        @(negedge i_clk);
        start   = 1'b1;
        i_cmd   = cmd;
        i_value = val;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Idle the request side, with junk on the payload.
    task automatic pause(int n);
        repeat (n) begin
            @(negedge i_clk);
            start   = 1'b0;
            i_cmd   = CMD_W'($urandom);
            i_value = $urandom;
        end
    endtask

    task automatic drain_results();
        pause(1);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    function automatic logic [CMD_W-1:0] pick_cmd(int push_pct);
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
        return $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_phase(int n, int push_pct, bit gapless);
        int sent;
        int burst;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(24, 1);
            for (int k = 0; k < burst && sent < n; k++) begin
                send_req(pick_cmd(push_pct), pick_value());
                sent++;
            end
            if (!gapless)
                pause($urandom_range(6, 0));
        end
    endtask

    initial begin
        logic [DATA_W-1:0] corner_vals [8];
        sb          = new();
        cycle_count = 0;
        start       = 1'b0;
        i_cmd       = CMD_PUSH_FRONT;
        i_value     = '0;
        i_rst_n     = 1'b0;
        corner_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0,
                        32'hAAAA_AAAA, 32'h5555_5555, 32'h1, 32'hFFFF_FFFE};
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Pops on an empty deque must underflow.
        send_req(CMD_POP_FRONT, 32'h1234_5678);
        send_req(CMD_POP_BACK, 32'hFFFF_FFFF);
        // Fill from both ends so the head wraps below zero, overflow both ways, then pop from each end.
        for (int k = 0; k < DQ_DEPTH; k++)
            send_req(k[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
                     k < 8 ? corner_vals[k] : $urandom);
        send_req(CMD_PUSH_FRONT, 32'hDEAD_BEEF);
        send_req(CMD_PUSH_BACK, 32'h0BAD_F00D);
        send_req(CMD_POP_FRONT, 32'h0);
        send_req(CMD_POP_BACK, 32'h0);
        drain_results();

        // Push-heavy and pop-heavy phases hit full and empty repeatedly.
        run_phase(100, 80, 1'b0);
        drain_results();
        run_phase(100, 20, 1'b0);
        run_phase(100, 50, 1'b1);
        drain_results();
        run_phase(100, 90, 1'b1);
        run_phase(100, 10, 1'b0);
        drain_results();
        run_phase(100, 55, 1'b0);

        pause(1);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/dq_pkg.sv
hdl/dq_ram.sv
hdl/dq_ctrl.sv
hdl/double_ended_queue_core.sv
verif/tb_top.sv
